// ===== design/vtc_pkg.sv =====
`timescale 1ns / 1ps

package vtc_pkg;

   localparam int TICKS_PER_SECOND = 1000;
   localparam int SETTLE_TICKS     = 100;

   localparam int MS_WIDTH  = 10;
   localparam int SEC_WIDTH = 9;

   localparam logic [MS_WIDTH-1:0]  TICK_LIMIT     = MS_WIDTH'(TICKS_PER_SECOND);
   localparam logic [MS_WIDTH-1:0]  SETTLE_LIMIT   = MS_WIDTH'(SETTLE_TICKS);
   localparam logic [SEC_WIDTH-1:0] SETTLE_SECONDS = SEC_WIDTH'(SETTLE_TICKS / TICKS_PER_SECOND);
   localparam logic [SEC_WIDTH-1:0] SEC_MAX        = '1;
   localparam bit                   SETTLE_USED    = (SETTLE_TICKS != 0);

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   localparam logic CSR_MAX_TRAVEL = 1'b0;
   localparam logic CSR_USE_POWER  = 1'b1;

   typedef enum logic [1:0] {
      POS_OPEN   = 2'd0,
      POS_CLOSED = 2'd1,
      POS_MID    = 2'd2
   } pos_type;

   typedef enum logic [2:0] {
      RC_NONE    = 3'd0,
      RC_REACHED = 3'd1,
      RC_ALREADY = 3'd2,
      RC_TIMEOUT = 3'd3,
      RC_BUSY    = 3'd4
   } rc_type;

   typedef struct packed {
      logic    op;
      logic    target;
      pos_type pos;
   } item_type;

   typedef struct packed {
      logic [7:0] max_travel_seconds;
      logic       use_power_relay;
   } cfg_type;

   typedef struct packed {
      logic                 valve_relay;
      logic                 power_relay;
      pos_type              position;
      logic                 busy;
      rc_type               code;
      logic [SEC_WIDTH-1:0] open_seconds;
      logic [SEC_WIDTH-1:0] close_seconds;
   } result_type;

   // The open switch wins when both are active.
   function automatic pos_type decode_pos(input logic open_n, input logic close_n);
      pos_type pos;
      if (!open_n) begin
         pos = POS_OPEN;
      end else if (!close_n) begin
         pos = POS_CLOSED;
      end else begin
         pos = POS_MID;
      end
      return pos;
   endfunction

   function automatic logic at_target(input pos_type pos, input logic tgt);
      return tgt ? (pos == POS_OPEN) : (pos == POS_CLOSED);
   endfunction

   function automatic logic [SEC_WIDTH-1:0] sat_inc(input logic [SEC_WIDTH-1:0] v);
      return (v == SEC_MAX) ? SEC_MAX : v + 1'b1;
   endfunction

endpackage

// ===== design/vtc_ctrl.sv =====
`timescale 1ns / 1ps

module vtc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  vtc_pkg::item_type   item,
   input  vtc_pkg::cfg_type    cfg,
   output vtc_pkg::result_type result
);
   import vtc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_TRAVEL = 2'd2
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic                 target_ff, target_in;
   logic [MS_WIDTH-1:0]  ms_count_ff, ms_count_in;
   logic [SEC_WIDTH-1:0] check_ff, check_in;
   logic [SEC_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [SEC_WIDTH-1:0] open_time_ff, open_time_in;
   logic [SEC_WIDTH-1:0] close_time_ff, close_time_in;
   logic                 valve_ff, valve_in;
   logic                 power_ff, power_in;

   logic [MS_WIDTH-1:0]  ms_inc;
   logic [SEC_WIDTH-1:0] check_inc;
   logic [SEC_WIDTH-1:0] elapsed_inc;
   rc_type               code;

   assign ms_inc      = ms_count_ff + 1'b1;
   assign check_inc   = sat_inc(check_ff);
   assign elapsed_inc = sat_inc(elapsed_ff);

   always_comb begin
      phase_in      = phase_ff;
      target_in     = target_ff;
      ms_count_in   = ms_count_ff;
      check_in      = check_ff;
      elapsed_in    = elapsed_ff;
      open_time_in  = open_time_ff;
      close_time_in = close_time_ff;
      valve_in      = valve_ff;
      power_in      = power_ff;
      code          = RC_NONE;

      if (item.op == OP_COMMAND) begin
         if (phase_ff == PH_SETTLE || phase_ff == PH_TRAVEL) begin
            code = RC_BUSY;
         end else if (at_target(item.pos, item.target)) begin
            code = RC_ALREADY;
         end else begin
            target_in   = item.target;
            ms_count_in = '0;
            check_in    = '0;
            elapsed_in  = '0;
            if (cfg.use_power_relay) begin
               power_in = 1'b1;
            end
            if (cfg.use_power_relay && SETTLE_USED) begin
               phase_in = PH_SETTLE;
            end else begin
               valve_in = item.target;
               phase_in = PH_TRAVEL;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_SETTLE: begin
               ms_count_in = ms_inc;
               if (ms_inc >= SETTLE_LIMIT) begin
                  valve_in    = target_ff;
                  elapsed_in  = SETTLE_SECONDS;
                  check_in    = '0;
                  ms_count_in = '0;
                  if (at_target(item.pos, target_ff)) begin
                     if (target_ff) begin
                        open_time_in = SETTLE_SECONDS;
                     end else begin
                        close_time_in = SETTLE_SECONDS;
                     end
                     power_in = 1'b0;
                     phase_in = PH_IDLE;
                     code     = RC_REACHED;
                  end else begin
                     phase_in = PH_TRAVEL;
                  end
               end
            end
            PH_TRAVEL: begin
               ms_count_in = ms_inc;
               if (ms_inc >= TICK_LIMIT) begin
                  ms_count_in = '0;
                  check_in    = check_inc;
                  elapsed_in  = elapsed_inc;
                  if (at_target(item.pos, target_ff)) begin
                     if (target_ff) begin
                        open_time_in = elapsed_inc;
                     end else begin
                        close_time_in = elapsed_inc;
                     end
                     power_in = 1'b0;
                     phase_in = PH_IDLE;
                     code     = RC_REACHED;
                  end else if (check_inc > {1'b0, cfg.max_travel_seconds}) begin
                     power_in = 1'b0;
                     phase_in = PH_IDLE;
                     code     = RC_TIMEOUT;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      result.valve_relay   = valve_in;
      result.power_relay   = power_in;
      result.position      = item.pos;
      result.busy          = (phase_in == PH_SETTLE) || (phase_in == PH_TRAVEL);
      result.code          = code;
      result.open_seconds  = open_time_in;
      result.close_seconds = close_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         target_ff     <= 1'b0;
         ms_count_ff   <= '0;
         check_ff      <= '0;
         elapsed_ff    <= '0;
         open_time_ff  <= '0;
         close_time_ff <= '0;
         valve_ff      <= 1'b0;
         power_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         target_ff     <= target_in;
         ms_count_ff   <= ms_count_in;
         check_ff      <= check_in;
         elapsed_ff    <= elapsed_in;
         open_time_ff  <= open_time_in;
         close_time_ff <= close_time_in;
         valve_ff      <= valve_in;
         power_ff      <= power_in;
      end
   end

endmodule

// ===== design/valve_travel_controller_unit.sv =====
`timescale 1ns / 1ps

// Ball valve travel controller. Each input word is either a one-millisecond tick or a
// move command, and each produces exactly one result word carrying the relay drives, the
// decoded limit-switch position, the busy flag, a result code and the last recorded open
// and close times. One word is taken every clock cycle while req_stall is low; a word passes
// through an input register and a result register, and the input register hands it on only
// when the result register is empty or being taken, so a stall on the result side holds it.
// The controller state is updated at the same clock edge that loads the result register.
// Configuration writes are always ready and take effect at once.

module valve_travel_controller_unit (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic       req_target,
   input  logic       req_open_switch_n,
   input  logic       req_close_switch_n,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valve_relay,
   output logic       rsp_power_relay,
   output logic [1:0] rsp_position,
   output logic       rsp_busy_res,
   output logic [2:0] rsp_result_code,
   output logic [8:0] rsp_last_open_seconds,
   output logic [8:0] rsp_last_close_seconds,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import vtc_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   item_type   item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       out_free;
   logic       fire;
   logic       take;

   // The result register frees up when it is empty or being taken this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   vtc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_travel_seconds <= 8'd8;
         cfg_ff.use_power_relay    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_TRAVEL: cfg_ff.max_travel_seconds <= csr_wdata;
            CSR_USE_POWER:  cfg_ff.use_power_relay    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.op     <= req_op;
         item_ff.target <= req_target;
         item_ff.pos    <= decode_pos(req_open_switch_n, req_close_switch_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_valve_relay        = out_ff.valve_relay;
   assign rsp_power_relay        = out_ff.power_relay;
   assign rsp_position           = out_ff.position;
   assign rsp_busy_res           = out_ff.busy;
   assign rsp_result_code        = out_ff.code;
   assign rsp_last_open_seconds  = out_ff.open_seconds;
   assign rsp_last_close_seconds = out_ff.close_seconds;

endmodule

// ===== dv/tb_valve_travel_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_valve_travel_controller_unit;
   import vtc_pkg::*;

   localparam int   CYCLE_LIMIT     = 3_000_000;
   localparam int   PHASE_ITEMS     = 207;

   typedef enum logic [1:0] {
      VT_IDLE   = 2'd0,
      VT_SETTLE = 2'd1,
      VT_TRAVEL = 2'd2
   } vt_phase_type;

   typedef struct {
      logic op;
      logic target;
      logic open_n;
      logic close_n;
      bit   drain;
   } valve_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = 1'b0;
   logic       req_target = 1'b0;
   logic       req_open_switch_n = 1'b1;
   logic       req_close_switch_n = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_valve_relay;
   logic       rsp_power_relay;
   logic [1:0] rsp_position;
   logic       rsp_busy_res;
   logic [2:0] rsp_result_code;
   logic [8:0] rsp_last_open_seconds;
   logic [8:0] rsp_last_close_seconds;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = 8'd0;

   valve_travel_controller_unit uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_op                 (req_op),
      .req_target             (req_target),
      .req_open_switch_n      (req_open_switch_n),
      .req_close_switch_n     (req_close_switch_n),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_valve_relay        (rsp_valve_relay),
      .rsp_power_relay        (rsp_power_relay),
      .rsp_position           (rsp_position),
      .rsp_busy_res           (rsp_busy_res),
      .rsp_result_code        (rsp_result_code),
      .rsp_last_open_seconds  (rsp_last_open_seconds),
      .rsp_last_close_seconds (rsp_last_close_seconds),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   valve_word_type pending_words[$];
   result_type     awaited_reports[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   bit          req_taken      = 1'b0;

   // Predicted controller state and register copies.
   logic [7:0]           cfg_max_travel;
   logic                 cfg_power;
   vt_phase_type         vt_phase;
   logic                 vt_target;
   logic [MS_WIDTH-1:0]  vt_ms;
   logic [SEC_WIDTH-1:0] vt_checks;
   logic [SEC_WIDTH-1:0] vt_elapsed;
   logic [SEC_WIDTH-1:0] vt_open_time;
   logic [SEC_WIDTH-1:0] vt_close_time;
   logic                 vt_valve;
   logic                 vt_power;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic pos_matches(input pos_type pos, input logic tgt);
      if (tgt) begin
         return pos == POS_OPEN;
      end
      return pos == POS_CLOSED;
   endfunction

   task automatic finish_arrival(output rc_type code);
      if (vt_target) begin
         vt_open_time = vt_elapsed;
      end else begin
         vt_close_time = vt_elapsed;
      end
      vt_power = 1'b0;
      vt_phase = VT_IDLE;
      code = RC_REACHED;
   endtask

   task automatic advance_valve(input logic op, input logic tgt, input logic open_n,
                                input logic close_n, output result_type res);
      pos_type pos;
      rc_type  code;
      if (!open_n) begin
         pos = POS_OPEN;
      end else if (!close_n) begin
         pos = POS_CLOSED;
      end else begin
         pos = POS_MID;
      end
      code = RC_NONE;
      if (op == OP_COMMAND) begin
         if (vt_phase != VT_IDLE) begin
            code = RC_BUSY;
         end else if (pos_matches(pos, tgt)) begin
            code = RC_ALREADY;
         end else begin
            vt_target  = tgt;
            vt_ms      = '0;
            vt_checks  = '0;
            vt_elapsed = '0;
            if (cfg_power) begin
               vt_power = 1'b1;
            end
            if (cfg_power && SETTLE_TICKS > 0) begin
               vt_phase = VT_SETTLE;
            end else begin
               vt_valve = tgt;
               vt_phase = VT_TRAVEL;
            end
         end
      end else if (vt_phase == VT_SETTLE) begin
         vt_ms = vt_ms + 1'b1;
         if (vt_ms >= SETTLE_TICKS) begin
            vt_valve   = vt_target;
            vt_elapsed = SEC_WIDTH'(SETTLE_TICKS / TICKS_PER_SECOND);
            vt_checks  = '0;
            vt_ms      = '0;
            if (pos_matches(pos, vt_target)) begin
               finish_arrival(code);
            end else begin
               vt_phase = VT_TRAVEL;
            end
         end
      end else if (vt_phase == VT_TRAVEL) begin
         vt_ms = vt_ms + 1'b1;
         if (vt_ms >= TICKS_PER_SECOND) begin
            vt_ms = '0;
            vt_checks  = (vt_checks == '1) ? vt_checks : vt_checks + 1'b1;
            vt_elapsed = (vt_elapsed == '1) ? vt_elapsed : vt_elapsed + 1'b1;
            if (pos_matches(pos, vt_target)) begin
               finish_arrival(code);
            end else if (vt_checks > cfg_max_travel) begin
               vt_power = 1'b0;
               vt_phase = VT_IDLE;
               code = RC_TIMEOUT;
            end
         end
      end
      res.valve_relay   = vt_valve;
      res.power_relay   = vt_power;
      res.position      = pos;
      res.busy          = (vt_phase != VT_IDLE);
      res.code          = code;
      res.open_seconds  = vt_open_time;
      res.close_seconds = vt_close_time;
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   // Driver: a word stays on the port until it is taken.
   always @(negedge clock) begin : drive_req
      valve_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct &&
             (!pending_words[0].drain || awaited_reports.size() == 0)) begin
            w = pending_words.pop_front();
            req_op             <= w.op;
            req_target         <= w.target;
            req_open_switch_n  <= w.open_n;
            req_close_switch_n <= w.close_n;
            req_valid          <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_ports
      result_type want;
      result_type fresh;
      if (reset) begin
         req_taken      = 1'b0;
         cfg_max_travel = 8'd8;
         cfg_power      = 1'b0;
         vt_phase       = VT_IDLE;
         vt_target      = 1'b0;
         vt_ms          = '0;
         vt_checks      = '0;
         vt_elapsed     = '0;
         vt_open_time   = '0;
         vt_close_time  = '0;
         vt_valve       = 1'b0;
         vt_power       = 1'b0;
      end else begin
         cycle_count++;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $display("%0t: result word with nothing awaited, code %0d", $time,
                        rsp_result_code);
               error_count++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("valve_relay", want.valve_relay, rsp_valve_relay);
               check_field("power_relay", want.power_relay, rsp_power_relay);
               check_field("position", want.position, rsp_position);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("result_code", want.code, rsp_result_code);
               check_field("last_open_seconds", want.open_seconds, rsp_last_open_seconds);
               check_field("last_close_seconds", want.close_seconds, rsp_last_close_seconds);
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            advance_valve(req_op, req_target, req_open_switch_n, req_close_switch_n, fresh);
            awaited_reports.push_back(fresh);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_TRAVEL) begin
               cfg_max_travel = csr_wdata;
            end else begin
               cfg_power = csr_wdata[0];
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("** valve_travel_controller_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic push_word(input logic op, input logic tgt, input logic [1:0] sw,
                            input bit drain);
      valve_word_type w;
      w.op      = op;
      w.target  = tgt;
      w.open_n  = sw[1];
      w.close_n = sw[0];
      w.drain   = drain;
      pending_words.push_back(w);
   endtask

   // Switch levels {open_n, close_n} that do not show the target position.
   function automatic logic [1:0] miss_switches(input logic tgt);
      logic [1:0] sw;
      sw = 2'($urandom_range(3));
      if (tgt) begin
         sw[1] = 1'b1;
      end else if (sw == 2'b10) begin
         sw = 2'b11;
      end
      return sw;
   endfunction

   function automatic logic [1:0] hit_switches(input logic tgt);
      if (tgt) begin
         return {1'b0, 1'($urandom_range(1))};
      end
      return 2'b10;
   endfunction

   // One move: the command, ticks up to the check that ends it, then idle ticks and commands that find the target.
   // A move that is to time out never shows the target at a check.
   task automatic gen_move(input logic tgt, input logic [1:0] start_sw, input int end_check,
                           input bit timeout, input bit power, inout int counted);
      int         settle;
      int         end_tick;
      int         prev_tick;
      int         arrive_tick;
      int         t;
      int         n;
      logic       t2;
      logic [1:0] sw;
      logic [1:0] cur_miss;
      settle    = power ? SETTLE_TICKS : 0;
      end_tick  = settle + TICKS_PER_SECOND * end_check;
      prev_tick = (end_check == (power ? 0 : 1)) ? 0 : end_tick - TICKS_PER_SECOND;
      arrive_tick = timeout ? end_tick + 1 : $urandom_range(end_tick, prev_tick + 1);
      push_word(OP_COMMAND, tgt, start_sw, $urandom_range(9) == 0);
      counted += end_tick + 1;
      cur_miss = start_sw;
      for (t = 1; t <= end_tick; t++) begin
         if ($urandom_range(299) == 0) begin
            push_word(OP_COMMAND, 1'($urandom_range(1)), 2'($urandom_range(3)), 1'b0);
            counted++;
         end
         if ($urandom_range(499) == 0) begin
            cur_miss = miss_switches(tgt);
         end
         if (t >= arrive_tick) begin
            sw = hit_switches(tgt);
         end else if (t >= settle && (t - settle) % TICKS_PER_SECOND == 0) begin
            sw = cur_miss;
         end else if ($urandom_range(99) == 0) begin
            // Contact bounce between checks may show anything.
            sw = 2'($urandom_range(3));
         end else begin
            sw = cur_miss;
         end
         push_word(OP_TICK, 1'($urandom_range(1)), sw, 1'b0);
      end
      n = $urandom_range(4, 1);
      counted += n;
      repeat (n) begin
         push_word(OP_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)), 1'b0);
      end
      n = $urandom_range(2);
      counted += n;
      repeat (n) begin
         t2 = 1'($urandom_range(1));
         push_word(OP_COMMAND, t2, hit_switches(t2), 1'b0);
      end
   endtask

   task automatic wait_quiet();
      while (pending_words.size() != 0 || awaited_reports.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int         counted;
      int         ph;
      int         r;
      int         k;
      int         plan_max;
      bit         plan_power;
      bit         timeout;
      logic       tgt;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset register values.
      counted = 0;
      push_word(OP_TICK, 1'b0, 2'b00, 1'b0);
      push_word(OP_TICK, 1'b1, 2'b01, 1'b0);
      push_word(OP_TICK, 1'b0, 2'b10, 1'b0);
      push_word(OP_TICK, 1'b1, 2'b11, 1'b0);
      push_word(OP_COMMAND, 1'b1, 2'b01, 1'b0);
      push_word(OP_COMMAND, 1'b1, 2'b00, 1'b0);
      push_word(OP_COMMAND, 1'b0, 2'b10, 1'b0);
      wait_quiet();
      write_reg(CSR_USE_POWER, 8'h01);
      // Both switches active decode as open, so closing starts; it arrives at settle end.
      gen_move(1'b0, 2'b00, 0, 1'b0, 1'b1, counted);
      wait_quiet();
      write_reg(CSR_MAX_TRAVEL, 8'd0);
      write_reg(CSR_USE_POWER, 8'hFE);
      gen_move(1'b1, 2'b11, 1, 1'b1, 1'b0, counted);
      gen_move(1'b0, 2'b01, 1, 1'b0, 1'b0, counted);

      for (ph = 0; ph < 8; ph++) begin
         wait_quiet();
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 62;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 62;
            end
            default: begin
               send_idle_pct  = 15;
               recv_stall_pct = 15;
            end
         endcase
         case (ph)
            0: begin
               plan_max = 0;
               plan_power = 1'b0;
            end
            1: begin
               plan_max = 255;
               plan_power = 1'b1;
            end
            2: begin
               plan_max = 1;
               plan_power = 1'b1;
            end
            3: begin
               plan_max = $urandom_range(254, 3);
               plan_power = 1'b0;
            end
            4: begin
               plan_max = 2;
               plan_power = 1'b1;
            end
            5: begin
               plan_max = 0;
               plan_power = 1'b1;
            end
            6: begin
               plan_max = 255;
               plan_power = 1'b0;
            end
            default: begin
               plan_max = $urandom_range(255);
               plan_power = 1'($urandom_range(1));
            end
         endcase
         write_reg(CSR_MAX_TRAVEL, 8'(plan_max));
         write_reg(CSR_USE_POWER, {7'($urandom_range(127)), plan_power});
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            tgt = 1'($urandom_range(1));
            r = $urandom_range(99);
            timeout = (plan_max <= 2 && r < 30);
            if (timeout) begin
               k = plan_max + 1;
            end else begin
               if (plan_power) begin
                  k = (r < 50) ? 0 : (r < 85) ? 1 : 2;
               end else begin
                  k = (r < 75) ? 1 : 2;
               end
               if (k > plan_max + 1) begin
                  k = plan_max + 1;
               end
            end
            gen_move(tgt, miss_switches(tgt), k, timeout, plan_power, counted);
         end
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("** valve_travel_controller_unit: PASSED **");
      end else begin
         $display("** valve_travel_controller_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/vtc_pkg.sv
design/vtc_ctrl.sv
design/valve_travel_controller_unit.sv
dv/tb_valve_travel_controller_unit.sv
